>>> src/cdq_pkg.sv
// Shared types and constants of the circular deque.
package cdq_pkg;

	localparam int VALUE_W = 32;
	localparam int CFG_W = 5;
	localparam int RING_SIZE_RESET = 16;
	localparam int RING_SIZE_MIN = 2;

	localparam logic signed [VALUE_W-1:0] POP_REFUSED_VALUE = -32'sd1;

	typedef enum logic [1:0] {
		CMD_PUSH_REAR  = 2'd0,
		CMD_PUSH_FRONT = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t                       command;
		logic signed [VALUE_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] pop_value;
		status_t                    status;
		logic                       now_empty;
		logic                       now_full;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_item;
		logic take_cfg;
		logic load_read;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_busy;
		logic pop_read;
	} dp_status_t;

endpackage

>>> src/cdq_ctrl.sv
// Controller state machine of the circular deque.
module cdq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                out_stall,
	input  cdq_pkg::dp_status_t st,
	output cdq_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        can_load;

	// The result register can take a new result when empty or drained this cycle.
	assign can_load = !st.out_busy || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		cfg_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cfg_ready = 1'b1;
				cmd.take_cfg = cfg_valid;
				in_stall = !(can_load && !cfg_valid);
				cmd.take_item = in_valid && !in_stall;
				if (cmd.take_item && st.pop_read) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.load_read = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_read_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_read |-> $past(cmd.take_item && st.pop_read))
		else $error("read data loaded without a pending pop");

	a_load_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_read |-> (!st.out_busy || !out_stall))
		else $error("read data loaded over an unconsumed result");

	a_no_item_and_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.take_item && cmd.take_cfg))
		else $error("item and configuration taken in the same cycle");

endmodule

>>> src/cdq_dpath.sv
// Datapath of the circular deque: pointers, ring memory and result register.
module cdq_dpath #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cdq_pkg::ctrl_cmd_t          cmd,
	output cdq_pkg::dp_status_t         st,
	input  cdq_pkg::in_item_t           in_data,
	input  logic [cdq_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        out_stall,
	output logic                        out_valid,
	output cdq_pkg::out_item_t          out_data
);

	localparam int IW = $clog2(MAX_SLOTS);
	localparam int SW = $clog2(MAX_SLOTS + 1);
	localparam int RESET_RING = (cdq_pkg::RING_SIZE_RESET > MAX_SLOTS) ?
		MAX_SLOTS : cdq_pkg::RING_SIZE_RESET;

	logic [SW-1:0] ring_q;
	logic [IW-1:0] front_q;
	logic [IW-1:0] rear_q;
	logic [IW-1:0] front_d;
	logic [IW-1:0] rear_d;

	logic signed [cdq_pkg::VALUE_W-1:0] mem [MAX_SLOTS];
	logic signed [cdq_pkg::VALUE_W-1:0] rd_q;

	logic               out_valid_q;
	cdq_pkg::out_item_t out_q;
	logic               pend_empty_q;
	logic               pend_full_q;

	logic          empty;
	logic          full;
	logic          is_push;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          empty_d;
	logic          full_d;
	logic [SW-1:0] ring_cfg;

	function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i,
			input logic [SW-1:0] ring);
		logic [SW:0] nxt;
		nxt = (SW+1)'(i) + (SW+1)'(1);
		return (nxt >= (SW+1)'(ring)) ? '0 : IW'(nxt);
	endfunction

	function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i,
			input logic [SW-1:0] ring);
		return (i == '0) ? IW'(ring - SW'(1)) : i - IW'(1);
	endfunction

	assign empty = (front_q == rear_q);
	assign full = (step_up(rear_q, ring_q) == front_q);
	assign is_push = (in_data.command == cdq_pkg::CMD_PUSH_REAR) ||
		(in_data.command == cdq_pkg::CMD_PUSH_FRONT);

	assign st.out_busy = out_valid_q;
	assign st.pop_read = !is_push && !empty;

	// Ring size written out of range is clamped to the legal span.
	always_comb begin
		if (32'(cfg_data) < cdq_pkg::RING_SIZE_MIN) begin
			ring_cfg = SW'(cdq_pkg::RING_SIZE_MIN);
		end else if (32'(cfg_data) > MAX_SLOTS) begin
			ring_cfg = SW'(MAX_SLOTS);
		end else begin
			ring_cfg = SW'(cfg_data);
		end
	end

	always_comb begin
		front_d = front_q;
		rear_d = rear_q;
		wr_en = 1'b0;
		wr_addr = front_q;
		rd_en = 1'b0;
		rd_addr = rear_q;
		case (in_data.command)
			cdq_pkg::CMD_PUSH_REAR: begin
				rear_d = step_up(rear_q, ring_q);
				wr_en = !full;
				wr_addr = rear_d;
			end
			cdq_pkg::CMD_PUSH_FRONT: begin
				// Write at the old front position, then move it back.
				front_d = step_down(front_q, ring_q);
				wr_en = !full;
				wr_addr = front_q;
			end
			cdq_pkg::CMD_POP_FRONT: begin
				front_d = step_up(front_q, ring_q);
				rd_en = !empty;
				rd_addr = front_d;
			end
			cdq_pkg::CMD_POP_REAR: begin
				rear_d = step_down(rear_q, ring_q);
				rd_en = !empty;
				rd_addr = rear_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
		if (!(wr_en || rd_en)) begin
			front_d = front_q;
			rear_d = rear_q;
		end
		empty_d = (front_d == rear_d);
		full_d = (step_up(rear_d, ring_q) == front_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= SW'(RESET_RING);
			front_q <= '0;
			rear_q <= '0;
		end else if (cmd.take_cfg) begin
			ring_q <= ring_cfg;
			front_q <= '0;
			rear_q <= '0;
		end else if (cmd.take_item) begin
			front_q <= front_d;
			rear_q <= rear_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item && wr_en) begin
			mem[wr_addr] <= in_data.push_value;
		end
		if (cmd.take_item && rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.take_item && !st.pop_read) || cmd.load_read) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			pend_empty_q <= empty_d;
			pend_full_q <= full_d;
			if (is_push) begin
				out_q.pop_value <= '0;
				out_q.status <= full ? cdq_pkg::ST_FULL : cdq_pkg::ST_DONE;
				out_q.now_empty <= empty_d;
				out_q.now_full <= full_d;
			end else if (empty) begin
				out_q.pop_value <= cdq_pkg::POP_REFUSED_VALUE;
				out_q.status <= cdq_pkg::ST_EMPTY;
				out_q.now_empty <= empty_d;
				out_q.now_full <= full_d;
			end
		end else if (cmd.load_read) begin
			out_q.pop_value <= rd_q;
			out_q.status <= cdq_pkg::ST_DONE;
			out_q.now_empty <= pend_empty_q;
			out_q.now_full <= pend_full_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	a_not_empty_and_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(empty && full))
		else $error("ring reports empty and full together");

	a_ring_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(ring_q) >= cdq_pkg::RING_SIZE_MIN) && (32'(ring_q) <= MAX_SLOTS))
		else $error("ring size outside its legal span");

	a_pointers_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		((SW+1)'(front_q) < (SW+1)'(ring_q)) && ((SW+1)'(rear_q) < (SW+1)'(ring_q)))
		else $error("pointer beyond the ring size");

endmodule

>>> src/circular_deque.sv
// Top level of the circular deque: controller and datapath.
//
// A double-ended queue kept on a ring of ring_size slots, holding at most
// ring_size - 1 signed 32-bit entries. Each input transaction carries a
// command (push rear, push front, pop front, pop rear) and a push value; each
// one gives exactly one output transaction with the popped value, a status
// code and the empty and full flags after the operation.
// Pushes and refused operations load the result register at the accepting
// edge, and a new transaction may be accepted every cycle unless held by a
// stalled receiver or a configuration write. A good pop reads the ring memory
// through its registered read port and moves the read data into the result
// register in the S_READ state, in which the input is stalled.
// The single output register lets a new transaction be taken in the cycle in
// which the receiver takes the previous result; when the receiver stalls with a
// result pending, the input is stalled too and the result holds.
// The configuration channel writes ring_size (clamped to 2..MAX_SLOTS) and
// empties the ring; it is meant to be used while the block is idle.
// Reset empties the ring and sets ring_size to 16 (or MAX_SLOTS if smaller);
// the memory content is not cleared.
module circular_deque #(
	parameter int MAX_SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  cdq_pkg::in_item_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output cdq_pkg::out_item_t         out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cdq_pkg::CFG_W-1:0]  cfg_data
);

	cdq_pkg::ctrl_cmd_t  cmd;
	cdq_pkg::dp_status_t st;

	// The controller decides when transactions are taken on each channel.
	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// The datapath holds the pointers, the ring memory and the result register.
	cdq_dpath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (in_data),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
